// ----- rtl/aabb_broad_phase_pair_finder_unit_defines.svh -----
// assertion macros shared by the broad phase pair finder rtl
`ifndef AABB_BROAD_PHASE_PAIR_FINDER_UNIT_DEFINES_SVH
`define AABB_BROAD_PHASE_PAIR_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AABBPF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aabbpf same-cycle check failed");

// next-cycle implication, disabled during reset
`define AABBPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aabbpf next-cycle check failed");

`endif

// ----- rtl/aabbpf_pkg.sv -----
// types, constants and helper functions of the broad phase pair finder
package aabbpf_pkg;

    localparam int MAX_BOXES     = 32;
    localparam int COORD_BITS    = 24;
    localparam int FIELD_BITS    = 24;
    localparam int OUT_SLOT_BITS = 5;
    localparam int SLOT_BITS     = (MAX_BOXES > 2) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_BITS      = $clog2(MAX_BOXES + 1);

    typedef logic signed [FIELD_BITS-1:0] t_coord_field;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [OUT_SLOT_BITS-1:0]     t_slot_field;
    typedef logic [SLOT_BITS-1:0]         t_slot;
    typedef logic [CNT_BITS-1:0]          t_count;
    typedef logic [1:0]                   t_status;

    localparam logic    OP_CLEAR       = 1'b0;
    localparam logic    OP_ADD         = 1'b1;
    localparam t_status STATUS_ADDED   = 2'd0;
    localparam t_status STATUS_FULL    = 2'd1;
    localparam t_status STATUS_CLEARED = 2'd2;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_ADD   = 2'd1,
        K_FULL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_box;

    typedef struct packed {
        logic        hit;
        t_slot_field earlier_slot;
        t_slot_field new_slot;
        t_status     status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    // low COORD_BITS of the field, sign extended past the field width
    function automatic t_coord coord_of(input t_coord_field v);
        t_coord r;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[i] = v[(i < FIELD_BITS) ? i : FIELD_BITS - 1];
        end
        return r;
    endfunction

    // slot index masked or zero extended to the result field
    function automatic t_slot_field slot_out(input t_slot s);
        t_slot_field r;
        for (int i = 0; i < OUT_SLOT_BITS; i++) begin
            r[i] = (i < SLOT_BITS) ? s[(i < SLOT_BITS) ? i : 0] : 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/aabbpf_if.sv -----
// valid/ready channel interfaces for box items and pair results
interface aabbpf_in_if import aabbpf_pkg::*; ();
    logic         valid;
    logic         ready;
    logic         op;
    t_coord_field min_x;
    t_coord_field min_y;
    t_coord_field min_z;
    t_coord_field max_x;
    t_coord_field max_y;
    t_coord_field max_z;

    modport source (
        output valid, op, min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );
    modport sink (
        input  valid, op, min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

interface aabbpf_out_if import aabbpf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        hit;
    t_slot_field earlier_slot;
    t_slot_field new_slot;
    t_status     status;
    logic        last;

    modport source (
        output valid, hit, earlier_slot, new_slot, status, last,
        input  ready
    );
    modport sink (
        input  valid, hit, earlier_slot, new_slot, status, last,
        output ready
    );
endinterface

// ----- rtl/aabbpf_cell.sv -----
// one ring cell holding a stored box, loadable or shifted from its neighbor
module aabbpf_cell import aabbpf_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_box       i_shift_box,
    input  t_box       i_load_box,
    output t_box       o_box
);

    t_box r_box;
    t_box n_box;

    always_comb begin
        n_box = r_box;
        if (i_ctrl.load) begin
            n_box = i_load_box;
        end else if (i_ctrl.shift) begin
            n_box = i_shift_box;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box <= n_box;
    end

    assign o_box = r_box;

endmodule

// ----- rtl/aabbpf_overlap.sv -----
// overlap test of two boxes, touching faces count as overlap
module aabbpf_overlap import aabbpf_pkg::*; (
    input  t_box i_stored,
    input  t_box i_query,
    output logic o_overlap
);

    logic apart;

    assign apart = (i_stored.max_x < i_query.min_x) || (i_stored.min_x > i_query.max_x) ||
                   (i_stored.max_y < i_query.min_y) || (i_stored.min_y > i_query.max_y) ||
                   (i_stored.max_z < i_query.min_z) || (i_stored.min_z > i_query.max_z);

    assign o_overlap = !apart;

endmodule

// ----- rtl/aabb_broad_phase_pair_finder_unit.sv -----
// top level of the brute force box broad phase pair finder
//
//  channel | dir | transfer when        | payload
//  i_in    | in  | i_in.valid & ready   | op, min_x..max_z
//  o_out   | out | o_out.valid & ready  | hit, earlier_slot, new_slot, status, last
//
// clear and store-full items skip the scan and go straight to the done state
// an add rotates the box ring one full turn past the single comparator at cell 0,
// one stored box per cycle while the ring is not frozen by a stalled output
// a stalled output freezes the ring only when a second overlap must be sent
// reset zeroes the box count; the cells themselves are not cleared
module aabb_broad_phase_pair_finder_unit import aabbpf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aabbpf_in_if.sink       i_in,
    aabbpf_out_if.source    o_out
);

`include "aabb_broad_phase_pair_finder_unit_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state  r_state, n_state;
    t_count  r_count, n_count;
    t_slot   r_idx, n_idx;
    t_kind   r_kind, n_kind;
    t_box    r_query, n_query;
    logic    r_pend_valid, n_pend_valid;
    t_slot   r_pend_slot, n_pend_slot;
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    t_box    cell_box [MAX_BOXES];
    logic    overlap;
    logic    out_free;
    logic    in_xfer;
    logic    hit_now;
    logic    advance;
    logic    done_fire;
    logic    write_box;
    t_result final_res;

    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer   = i_in.valid && i_in.ready;

    aabbpf_overlap u_overlap (
        .i_stored  (cell_box[0]),
        .i_query   (r_query),
        .o_overlap (overlap)
    );

    assign hit_now   = (r_state == S_SCAN) && (CNT_BITS'(r_idx) < r_count) && overlap;
    assign advance   = (r_state == S_SCAN) && !(hit_now && r_pend_valid && !out_free);
    assign done_fire = (r_state == S_DONE) && out_free;
    assign write_box = done_fire && (r_kind == K_ADD);

    // ring of cells, rotating toward cell 0
    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        localparam int NEXT = (k + 1) % MAX_BOXES;
        t_cell_ctrl ctrl;

        assign ctrl.shift = advance;
        assign ctrl.load  = write_box && (r_count[SLOT_BITS-1:0] == SLOT_BITS'(k));

        aabbpf_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_shift_box (cell_box[NEXT]),
            .i_load_box  (r_query),
            .o_box       (cell_box[k])
        );
    end

    always_comb begin
        final_res = '0;
        final_res.last = 1'b1;
        case (r_kind)
            K_CLEAR: final_res.status = STATUS_CLEARED;
            K_FULL:  final_res.status = STATUS_FULL;
            default: begin
                final_res.status   = STATUS_ADDED;
                final_res.new_slot = slot_out(r_count[SLOT_BITS-1:0]);
                if (r_pend_valid) begin
                    final_res.hit          = 1'b1;
                    final_res.earlier_slot = slot_out(r_pend_slot);
                end
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_kind       = r_kind;
        n_query      = r_query;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_idx        = '0;
                    n_pend_valid = 1'b0;
                    n_query.min_x = coord_of(i_in.min_x);
                    n_query.min_y = coord_of(i_in.min_y);
                    n_query.min_z = coord_of(i_in.min_z);
                    n_query.max_x = coord_of(i_in.max_x);
                    n_query.max_y = coord_of(i_in.max_y);
                    n_query.max_z = coord_of(i_in.max_z);
                    if (i_in.op == OP_CLEAR) begin
                        n_kind  = K_CLEAR;
                        n_state = S_DONE;
                    end else if (r_count == CNT_BITS'(MAX_BOXES)) begin
                        n_kind  = K_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_kind  = K_ADD;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (advance) begin
                    if (hit_now) begin
                        if (r_pend_valid) begin
                            n_out_valid           = 1'b1;
                            n_out.hit             = 1'b1;
                            n_out.earlier_slot    = slot_out(r_pend_slot);
                            n_out.new_slot        = slot_out(r_count[SLOT_BITS-1:0]);
                            n_out.status          = STATUS_ADDED;
                            n_out.last            = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_idx;
                    end
                    n_idx = r_idx + 1'b1;
                    if (r_idx == SLOT_BITS'(MAX_BOXES - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (done_fire) begin
                    n_out_valid  = 1'b1;
                    n_out        = final_res;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                    if (r_kind == K_CLEAR) begin
                        n_count = '0;
                    end else if (r_kind == K_ADD) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_kind      <= n_kind;
        r_query     <= n_query;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.hit          = r_out.hit;
    assign o_out.earlier_slot = r_out.earlier_slot;
    assign o_out.new_slot     = r_out.new_slot;
    assign o_out.status       = r_out.status;
    assign o_out.last         = r_out.last;

    `AABBPF_ASSERT_IMPL(a_pend_only_busy, r_pend_valid, r_state != S_IDLE)
    `AABBPF_ASSERT_NEXT(a_scan_ends_done, advance && (r_idx == SLOT_BITS'(MAX_BOXES - 1)),
        r_state == S_DONE)
    `AABBPF_ASSERT_NEXT(a_add_counts, write_box, r_count == $past(r_count) + 1'b1)
    `AABBPF_ASSERT_IMPL(a_count_range, r_state == S_SCAN, r_count < CNT_BITS'(MAX_BOXES))

endmodule
